/* sv/bph_pkg.sv */
`default_nettype none

package bph_pkg;

   localparam int BYTE_W = 8;
   localparam int ACC_W = 10;
   localparam int MIX_W = 12;
   localparam int BUCKET_W = 10;
   localparam int SPLIT_W = 5;

   localparam int POLY_BASE = 241;
   localparam int POLY_MOD = 919;
   localparam int MIX_MUL = 211;
   localparam int MIX_ADD = 521;
   localparam int MIX_MOD = 2909;

   localparam int BUCKETS_DEFAULT = 1024;
   localparam int QUEUE_DEPTH = 4;

   localparam int MAG_ENTRIES = 1 << BYTE_W;
   localparam int SPLIT_ENTRIES = 1 << SPLIT_W;

   typedef struct packed {
      logic [ACC_W-1:0] term;
      logic             last;
   } item_type;

   typedef logic [ACC_W-1:0] mag_tab_type [MAG_ENTRIES];
   typedef logic [ACC_W-1:0] acc_tab_type [SPLIT_ENTRIES];
   typedef logic [MIX_W-1:0] mix_tab_type [SPLIT_ENTRIES];

   // Weighted magnitude of each raw byte pattern: |b| * 241 mod 919.
   function automatic mag_tab_type build_mag_tab();
      int          mag;
      mag_tab_type t;
      for (int i = 0; i < MAG_ENTRIES; i++) begin
         mag = (i >= MAG_ENTRIES / 2) ? MAG_ENTRIES - i : i;
         t[i] = ACC_W'((mag * POLY_BASE) % POLY_MOD);
      end
      return t;
   endfunction

   function automatic acc_tab_type build_acc_tab(input int shift);
      acc_tab_type t;
      for (int i = 0; i < SPLIT_ENTRIES; i++) begin
         t[i] = ACC_W'(((i << shift) * POLY_BASE) % POLY_MOD);
      end
      return t;
   endfunction

   function automatic mix_tab_type build_mix_tab(input int shift);
      mix_tab_type t;
      for (int i = 0; i < SPLIT_ENTRIES; i++) begin
         t[i] = MIX_W'(((i << shift) * MIX_MUL) % MIX_MOD);
      end
      return t;
   endfunction

   localparam mag_tab_type MAG_TAB = build_mag_tab();
   localparam acc_tab_type ACC_HI_TAB = build_acc_tab(SPLIT_W);
   localparam acc_tab_type ACC_LO_TAB = build_acc_tab(0);
   localparam mix_tab_type MIX_HI_TAB = build_mix_tab(SPLIT_W);
   localparam mix_tab_type MIX_LO_TAB = build_mix_tab(0);

endpackage

`default_nettype wire

/* sv/bph_front.sv */
`default_nettype none

module bph_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic signed [bph_pkg::BYTE_W-1:0] req_key_byte,
   input  wire logic                             req_last_byte,
   output logic                                  out_valid,
   input  wire logic                             out_ready,
   output bph_pkg::item_type                     out_item
);

   logic              valid_ff;
   logic              valid_in;
   bph_pkg::item_type item_ff;
   bph_pkg::item_type item_in;

   assign req_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_item = item_ff;

   always_comb begin
      valid_in = valid_ff;
      item_in = item_ff;
      if (req_ready) begin
         valid_in = req_valid;
         if (req_valid) begin
            item_in.term = bph_pkg::MAG_TAB[$unsigned(req_key_byte)];
            item_in.last = req_last_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

endmodule

`default_nettype wire

/* sv/bph_queue.sv */
`default_nettype none

module bph_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire bph_pkg::item_type push_item,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output bph_pkg::item_type      pop_item
);

   localparam int PTR_W = $clog2(bph_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(bph_pkg::QUEUE_DEPTH + 1);

   bph_pkg::item_type mem_ff [bph_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              push;
   logic              pop;

   assign push_ready = count_ff != CNT_W'(bph_pkg::QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_item = mem_ff[rd_ptr_ff];
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(bph_pkg::QUEUE_DEPTH))
      else $error("Queue count exceeds its depth.");

   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("Queue count did not follow a push.");

endmodule

`default_nettype wire

/* sv/bph_horner.sv */
`default_nettype none

module bph_horner (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      pop_valid,
   output logic                           pop_ready,
   input  wire bph_pkg::item_type         pop_item,
   output logic                           sum_valid,
   input  wire logic                      sum_ready,
   output logic [bph_pkg::ACC_W-1:0]      sum_value
);

   localparam int FOLD_W = bph_pkg::ACC_W + 2;

   logic [bph_pkg::ACC_W-1:0] acc_ff;
   logic [bph_pkg::ACC_W-1:0] acc_in;
   logic [FOLD_W-1:0]         fold;
   logic [FOLD_W-1:0]         reduced;

   assign pop_ready = !pop_item.last || sum_ready;
   assign sum_valid = pop_valid && pop_item.last;
   assign sum_value = reduced[bph_pkg::ACC_W-1:0];

   always_comb begin
      fold = FOLD_W'(bph_pkg::ACC_HI_TAB[acc_ff[bph_pkg::ACC_W-1:bph_pkg::SPLIT_W]])
           + FOLD_W'(bph_pkg::ACC_LO_TAB[acc_ff[bph_pkg::SPLIT_W-1:0]])
           + FOLD_W'(pop_item.term);
      if (fold >= FOLD_W'(2 * bph_pkg::POLY_MOD)) begin
         reduced = fold - FOLD_W'(2 * bph_pkg::POLY_MOD);
      end else if (fold >= FOLD_W'(bph_pkg::POLY_MOD)) begin
         reduced = fold - FOLD_W'(bph_pkg::POLY_MOD);
      end else begin
         reduced = fold;
      end
      acc_in = acc_ff;
      if (pop_valid && pop_ready) begin
         acc_in = pop_item.last ? '0 : reduced[bph_pkg::ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else begin
         acc_ff <= acc_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      acc_ff < bph_pkg::ACC_W'(bph_pkg::POLY_MOD))
      else $error("Accumulator left its residue range.");

endmodule

`default_nettype wire

/* sv/bph_finish.sv */
`default_nettype none

module bph_finish #(
   parameter int BUCKETS = bph_pkg::BUCKETS_DEFAULT
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        sum_valid,
   output logic                             sum_ready,
   input  wire logic [bph_pkg::ACC_W-1:0]   sum_value,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [bph_pkg::BUCKET_W-1:0]     rsp_bucket_index
);

   localparam int MIX_W = bph_pkg::MIX_W;
   localparam int MFOLD_W = MIX_W + 1;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_W = RECIP_SHIFT + 1;
   localparam int PROD_W = MIX_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / BUCKETS);
   localparam logic [MIX_W-1:0] BUCKET_C = MIX_W'(BUCKETS);

   logic                        v1_ff, v1_in;
   logic                        v2_ff, v2_in;
   logic                        v3_ff, v3_in;
   logic                        vo_ff, vo_in;
   logic [bph_pkg::ACC_W-1:0]   sum_ff, sum_in;
   logic [MIX_W-1:0]            mix_ff, mix_in;
   logic [MIX_W-1:0]            quo_ff, quo_in;
   logic [MIX_W-1:0]            mix3_ff, mix3_in;
   logic [bph_pkg::BUCKET_W-1:0] bucket_ff, bucket_in;
   logic                        ready1, ready2, ready3, ready_out;
   logic [MFOLD_W-1:0]          mfold;
   logic [PROD_W-1:0]           prod;
   logic [2*MIX_W-1:0]          qb;
   logic [MIX_W-1:0]            rem;

   assign ready_out = !vo_ff || rsp_ready;
   assign ready3 = !v3_ff || ready_out;
   assign ready2 = !v2_ff || ready3;
   assign ready1 = !v1_ff || ready2;
   assign sum_ready = ready1;
   assign rsp_valid = vo_ff;
   assign rsp_bucket_index = bucket_ff;

   always_comb begin
      mfold = MFOLD_W'(bph_pkg::MIX_HI_TAB[sum_ff[bph_pkg::ACC_W-1:bph_pkg::SPLIT_W]])
            + MFOLD_W'(bph_pkg::MIX_LO_TAB[sum_ff[bph_pkg::SPLIT_W-1:0]])
            + MFOLD_W'(bph_pkg::MIX_ADD);
      if (mfold >= MFOLD_W'(2 * bph_pkg::MIX_MOD)) begin
         mfold = mfold - MFOLD_W'(2 * bph_pkg::MIX_MOD);
      end else if (mfold >= MFOLD_W'(bph_pkg::MIX_MOD)) begin
         mfold = mfold - MFOLD_W'(bph_pkg::MIX_MOD);
      end
      prod = PROD_W'(mix_ff) * PROD_W'(RECIP);
      qb = (2 * MIX_W)'(quo_ff) * (2 * MIX_W)'(BUCKET_C);
      rem = mix3_ff - qb[MIX_W-1:0];
      if (rem >= BUCKET_C) begin
         rem = rem - BUCKET_C;
      end

      v1_in = ready1 ? sum_valid : v1_ff;
      sum_in = (ready1 && sum_valid) ? sum_value : sum_ff;
      v2_in = ready2 ? v1_ff : v2_ff;
      mix_in = (ready2 && v1_ff) ? mfold[MIX_W-1:0] : mix_ff;
      v3_in = ready3 ? v2_ff : v3_ff;
      quo_in = (ready3 && v2_ff) ? prod[RECIP_SHIFT +: MIX_W] : quo_ff;
      mix3_in = (ready3 && v2_ff) ? mix_ff : mix3_ff;
      vo_in = ready_out ? v3_ff : vo_ff;
      bucket_in = (ready_out && v3_ff) ? rem[bph_pkg::BUCKET_W-1:0] : bucket_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         vo_ff <= vo_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      mix_ff <= mix_in;
      quo_ff <= quo_in;
      mix3_ff <= mix3_in;
      bucket_ff <= bucket_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      v2_ff |-> (mix_ff < MIX_W'(bph_pkg::MIX_MOD)))
      else $error("Mixed value left its residue range.");

   assert property (@(posedge clock) disable iff (reset)
      (vo_ff && (BUCKETS <= (1 << bph_pkg::BUCKET_W)))
      |-> (MIX_W'(bucket_ff) < BUCKET_C))
      else $error("Bucket index is not below the bucket count.");

endmodule

`default_nettype wire

/* sv/byte_polynomial_bucket_hash_top.sv */
// A result passes the front register, the queue, the accumulator update and the finish stages.
// Throughput: one key byte per cycle while nothing stalls, set by the accumulator update
// loop (two table lookups, a three-input add and a compare-subtract).
// Between bytes and results a four-entry queue and a four-stage hash pipeline
// let the input and output sides stall on their own.
// Reset clears the accumulator, the queue and all valid flags; no item is held.
`default_nettype none

module byte_polynomial_bucket_hash_top #(
   parameter int BUCKETS = bph_pkg::BUCKETS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [bph_pkg::BYTE_W-1:0] req_key_byte,
   input  wire logic                              req_last_byte,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [bph_pkg::BUCKET_W-1:0]           rsp_bucket_index
);

   logic                      front_valid;
   logic                      front_ready;
   bph_pkg::item_type         front_item;
   logic                      pop_valid;
   logic                      pop_ready;
   bph_pkg::item_type         pop_item;
   logic                      sum_valid;
   logic                      sum_ready;
   logic [bph_pkg::ACC_W-1:0] sum_value;

   bph_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_key_byte  (req_key_byte),
      .req_last_byte (req_last_byte),
      .out_valid     (front_valid),
      .out_ready     (front_ready),
      .out_item      (front_item)
   );

   bph_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   bph_horner u_horner (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .sum_valid (sum_valid),
      .sum_ready (sum_ready),
      .sum_value (sum_value)
   );

   bph_finish #(
      .BUCKETS (BUCKETS)
   ) u_finish (
      .clock            (clock),
      .reset            (reset),
      .sum_valid        (sum_valid),
      .sum_ready        (sum_ready),
      .sum_value        (sum_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bucket_index (rsp_bucket_index)
   );

endmodule

`default_nettype wire
